// File: hdl/block_lace_size_parser_assert.svh
// Assertion macros for the lace size parser.
// Used by blsp_back, the only module that carries concurrent checks; no other dependencies.
`ifndef BLOCK_LACE_SIZE_PARSER_ASSERT_SVH
`define BLOCK_LACE_SIZE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define BLSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BLSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/blsp_pkg.sv
// Shared types, constants and helper functions of the lace size parser.
// No dependencies; used by every module of the block.
package blsp_pkg;

   // widest frame size handled and longest variable-length integer
   localparam int SIZE_WIDTH        = 32;
   localparam int MAX_INTEGER_BYTES = 8;

   localparam int ACC_W   = 7 * MAX_INTEGER_BYTES;
   localparam int EB_W    = ((ACC_W > SIZE_WIDTH) ? ACC_W : SIZE_WIDTH) + 2;
   localparam int TOTAL_W = 33;
   localparam int USED_W  = TOTAL_W + 1;
   localparam int SUM_W   = ((SIZE_WIDTH > TOTAL_W) ? SIZE_WIDTH : TOTAL_W) + 1;
   localparam int LEN_W   = 4;

   localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

   // fixed lacing divider: 32-bit payload by count of 1..256
   localparam int DIV_W     = 32;
   localparam int DVS_W     = 9;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // queue depths (powers of two)
   localparam int IQ_DEPTH = 4;
   localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
   localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // lacing modes
   localparam logic [1:0] LACE_NONE  = 2'd0;
   localparam logic [1:0] LACE_XIPH  = 2'd1;
   localparam logic [1:0] LACE_FIXED = 2'd2;
   localparam logic [1:0] LACE_EBML  = 2'd3;

   // error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_FIXED = 2'd1;
   localparam logic [1:0] ERR_RANGE = 2'd2;
   localparam logic [1:0] ERR_INT   = 2'd3;

   // item classes assigned by the front end
   localparam logic [2:0] KIND_BYTE        = 3'd0;
   localparam logic [2:0] KIND_NONE        = 3'd1;
   localparam logic [2:0] KIND_FIXED_EMPTY = 3'd2;
   localparam logic [2:0] KIND_FIXED       = 3'd3;
   localparam logic [2:0] KIND_SINGLE      = 3'd4;
   localparam logic [2:0] KIND_MULTI       = 3'd5;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  lacing;
      logic [31:0] data_size;
      logic [7:0]  header_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] frame_size;
      logic [7:0]  frame_index;
      logic [8:0]  repeat_count;
      logic        last;
      logic [1:0]  error;
   } rsp_item_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_stat_type;

   // length of a variable-length integer from its first byte (byte nonzero)
   function automatic logic [LEN_W-1:0] first_len(input logic [7:0] b);
      logic [LEN_W-1:0] len;
      len = LEN_W'(8);
      for (int i = 0; i < 8; i++) begin
         if (b[i]) len = LEN_W'(8 - i);
      end
      return len;
   endfunction

   function automatic rsp_item_type make_rsp(input logic [31:0] size,
                                             input logic [7:0]  idx,
                                             input logic [8:0]  rep,
                                             input logic        lst,
                                             input logic [1:0]  err);
      rsp_item_type r;
      r.frame_size   = size;
      r.frame_index  = idx;
      r.repeat_count = rep;
      r.last         = lst;
      r.error        = err;
      return r;
   endfunction

endpackage

// File: hdl/blsp_front.sv
// Input queue of the lace size parser: accepts items and tags each with its class.
// Depends on blsp_pkg.
module blsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_start_req,
   input  logic [1:0]            req_lacing,
   input  logic [31:0]           req_data_size,
   input  logic [7:0]            req_header_byte,
   output blsp_pkg::req_item_type head,
   output logic                  head_valid,
   input  logic                  pop
);

   blsp_pkg::req_item_type mem_ff [blsp_pkg::IQ_DEPTH];
   blsp_pkg::req_item_type item_in;

   logic [blsp_pkg::IQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [blsp_pkg::IQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [blsp_pkg::IQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          do_push, do_pop;

   assign full       = (cnt_ff == blsp_pkg::IQ_CNT_W'(blsp_pkg::IQ_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // classification
   always_comb begin
      item_in.lacing      = req_lacing;
      item_in.data_size   = req_data_size;
      item_in.header_byte = req_header_byte;
      if (!req_start_req) begin
         item_in.kind = blsp_pkg::KIND_BYTE;
      end else if (req_lacing == blsp_pkg::LACE_NONE) begin
         item_in.kind = blsp_pkg::KIND_NONE;
      end else if (req_lacing == blsp_pkg::LACE_FIXED) begin
         item_in.kind = (req_data_size == 32'd0) ? blsp_pkg::KIND_FIXED_EMPTY
                                                 : blsp_pkg::KIND_FIXED;
      end else begin
         item_in.kind = (req_header_byte == 8'd0) ? blsp_pkg::KIND_SINGLE
                                                  : blsp_pkg::KIND_MULTI;
      end
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: hdl/blsp_divider.sv
// Restoring divider for fixed lacing: one quotient bit per cycle.
// Depends on blsp_pkg.
module blsp_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  blsp_pkg::div_req_type  req,
   output blsp_pkg::div_stat_type stat
);

   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [blsp_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [blsp_pkg::DIV_W-1:0]      quo_ff, quo_in;
   logic [blsp_pkg::DVS_W-1:0]      rem_ff, rem_in;
   logic [blsp_pkg::DVS_W-1:0]      dvs_ff, dvs_in;
   logic [blsp_pkg::DVS_W:0]        rem_shift;
   logic [blsp_pkg::DVS_W+1:0]      trial;

   assign rem_shift = {rem_ff, quo_ff[blsp_pkg::DIV_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         run_in  = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (run_ff) begin
         // negative trial: keep the shifted remainder, quotient bit 0
         if (trial[blsp_pkg::DVS_W+1]) begin
            rem_in = rem_shift[blsp_pkg::DVS_W-1:0];
         end else begin
            rem_in = trial[blsp_pkg::DVS_W-1:0];
         end
         quo_in = {quo_ff[blsp_pkg::DIV_W-2:0], ~trial[blsp_pkg::DVS_W+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == blsp_pkg::DIV_CNT_W'(blsp_pkg::DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy      = run_ff;
   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

// File: hdl/blsp_rsp_queue.sv
// Result queue of the lace size parser, between the sequencer and the output ports.
// Depends on blsp_pkg.
module blsp_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr,
   input  blsp_pkg::rsp_item_type wr_data,
   output logic                   wr_full,
   output logic                   empty,
   input  logic                   pop,
   output blsp_pkg::rsp_item_type head
);

   blsp_pkg::rsp_item_type mem_ff [blsp_pkg::RQ_DEPTH];

   logic [blsp_pkg::RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [blsp_pkg::RQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [blsp_pkg::RQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          do_wr, do_pop;

   assign wr_full = (cnt_ff == blsp_pkg::RQ_CNT_W'(blsp_pkg::RQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_wr   = wr && !wr_full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({do_wr, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: hdl/blsp_back.sv
// Lace parsing sequencer: block state, size arithmetic and result generation.
// Depends on blsp_pkg, blsp_divider status and block_lace_size_parser_assert.svh.
`include "block_lace_size_parser_assert.svh"

module blsp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  blsp_pkg::req_item_type q_head,
   input  logic                   q_valid,
   output logic                   q_pop,
   output blsp_pkg::div_req_type  div_req,
   input  blsp_pkg::div_stat_type div_stat,
   output logic                   rsp_wr,
   output blsp_pkg::rsp_item_type rsp_data,
   input  logic                   rsp_full
);

   localparam int SW     = blsp_pkg::SIZE_WIDTH;
   localparam int ACC_W  = blsp_pkg::ACC_W;
   localparam int EB_W   = blsp_pkg::EB_W;
   localparam int TOT_W  = blsp_pkg::TOTAL_W;
   localparam int USED_W = blsp_pkg::USED_W;
   localparam int SUM_W  = blsp_pkg::SUM_W;
   localparam int LEN_W  = blsp_pkg::LEN_W;

   localparam logic [SW:0] XLIM = {1'b0, {SW{1'b1}}};
   localparam logic [SW:0] XSAT = {1'b1, {SW{1'b0}}};

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV      = 3'd1;
   localparam logic [2:0] ST_EB_SUB   = 3'd2;
   localparam logic [2:0] ST_EB_ADD   = 3'd3;
   localparam logic [2:0] ST_FRAME    = 3'd4;
   localparam logic [2:0] ST_LAST_SUM = 3'd5;
   localparam logic [2:0] ST_LAST_OUT = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic              active_ff, active_in;
   logic [1:0]        mode_ff, mode_in;
   logic [7:0]        sizes_left_ff, sizes_left_in;
   logic [7:0]        next_index_ff, next_index_in;
   logic [31:0]       block_length_ff, block_length_in;
   logic [31:0]       header_length_ff, header_length_in;
   logic [SW:0]       xacc_ff, xacc_in;
   logic [ACC_W-1:0]  eacc_ff, eacc_in;
   logic [LEN_W-1:0]  ibl_ff, ibl_in;
   logic [LEN_W-1:0]  ilen_ff, ilen_in;
   logic [SW-1:0]     prev_ff, prev_in;
   logic [TOT_W-1:0]  total_ff, total_in;

   // datapath staging
   logic [SW-1:0]     size_ff, size_in;
   logic [EB_W-1:0]   delta_ff, delta_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [8:0]        count_ff, count_in;

   logic [7:0]        hb;
   logic [SW:0]       x_sum, x_sat;
   logic [LEN_W-1:0]  e_len, e_bl_next;
   logic              e_first, e_bad;
   logic [ACC_W-1:0]  e_acc_next;
   logic [5:0]        b_shift;
   logic [EB_W-1:0]   bias, base, e_sum;
   logic              e_range;
   logic [SUM_W-1:0]  t_sum;
   logic [TOT_W-1:0]  t_sat;
   logic [USED_W-1:0] l_diff;

   assign hb = q_head.header_byte;

   // xiph: running sum saturates one above the size limit
   assign x_sum = xacc_ff + (SW+1)'(hb);
   assign x_sat = (x_sum > XLIM) ? XSAT : x_sum;

   // ebml integer assembly
   assign e_first    = (ibl_ff == '0);
   assign e_len      = blsp_pkg::first_len(hb);
   assign e_bad      = e_first &&
                       ((hb == 8'd0) || (e_len > LEN_W'(blsp_pkg::MAX_INTEGER_BYTES)));
   assign e_acc_next = e_first ? ACC_W'(hb & (8'hFF >> e_len))
                               : {eacc_ff[ACC_W-9:0], hb};
   assign e_bl_next  = e_first ? e_len - 1'b1 : ibl_ff - 1'b1;

   // signed delta bias 2^(7*len-1)-1; first size is read unbiased
   assign b_shift = 6'(ilen_ff) * 6'd7 - 6'd1;
   assign bias    = (next_index_ff == 8'd0) ? '0 : (EB_W'(1) << b_shift) - EB_W'(1);
   assign base    = (next_index_ff == 8'd0) ? '0 : EB_W'(prev_ff);
   assign e_sum   = base + delta_ff;
   assign e_range = e_sum[EB_W-1] || (e_sum > EB_W'({SW{1'b1}}));

   assign t_sum = SUM_W'(total_ff) + SUM_W'(size_ff);
   assign t_sat = (t_sum > SUM_W'(blsp_pkg::TOTAL_SAT)) ? blsp_pkg::TOTAL_SAT
                                                        : TOT_W'(t_sum);

   assign l_diff = USED_W'(block_length_ff) - used_ff;

   always_comb begin
      state_in         = state_ff;
      active_in        = active_ff;
      mode_in          = mode_ff;
      sizes_left_in    = sizes_left_ff;
      next_index_in    = next_index_ff;
      block_length_in  = block_length_ff;
      header_length_in = header_length_ff;
      xacc_in          = xacc_ff;
      eacc_in          = eacc_ff;
      ibl_in           = ibl_ff;
      ilen_in          = ilen_ff;
      prev_in          = prev_ff;
      total_in         = total_ff;
      size_in          = size_ff;
      delta_in         = delta_ff;
      used_in          = used_ff;
      count_in         = count_ff;
      q_pop            = 1'b0;
      rsp_wr           = 1'b0;
      rsp_data         = blsp_pkg::make_rsp(32'd0, next_index_ff, 9'd1, 1'b1,
                                            blsp_pkg::ERR_OK);
      div_req          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_full) begin
               q_pop = 1'b1;
               if (q_head.kind != blsp_pkg::KIND_BYTE) begin
                  // every start drops the block in progress
                  active_in        = 1'b0;
                  mode_in          = q_head.lacing;
                  sizes_left_in    = 8'd0;
                  next_index_in    = 8'd0;
                  block_length_in  = q_head.data_size;
                  header_length_in = 32'd1;
                  xacc_in          = '0;
                  eacc_in          = '0;
                  ibl_in           = '0;
                  ilen_in          = '0;
                  prev_in          = '0;
                  total_in         = '0;
               end
               unique case (q_head.kind)
                  blsp_pkg::KIND_NONE: begin
                     header_length_in = 32'd0;
                     rsp_wr   = 1'b1;
                     rsp_data = blsp_pkg::make_rsp(q_head.data_size, 8'd0, 9'd1, 1'b1,
                                                   blsp_pkg::ERR_OK);
                  end
                  blsp_pkg::KIND_FIXED_EMPTY: begin
                     rsp_wr   = 1'b1;
                     rsp_data = blsp_pkg::make_rsp(32'd0, 8'd0, 9'd1, 1'b1,
                                                   blsp_pkg::ERR_RANGE);
                  end
                  blsp_pkg::KIND_FIXED: begin
                     div_req.start    = 1'b1;
                     div_req.dividend = q_head.data_size - 32'd1;
                     div_req.divisor  = {1'b0, hb} + 9'd1;
                     count_in         = {1'b0, hb} + 9'd1;
                     state_in         = ST_DIV;
                  end
                  blsp_pkg::KIND_SINGLE: begin
                     state_in = ST_LAST_SUM;
                  end
                  blsp_pkg::KIND_MULTI: begin
                     sizes_left_in = hb;
                     active_in     = 1'b1;
                  end
                  blsp_pkg::KIND_BYTE: begin
                     if (active_ff) begin
                        if (header_length_ff != '1) begin
                           header_length_in = header_length_ff + 32'd1;
                        end
                        if (mode_ff == blsp_pkg::LACE_XIPH) begin
                           if (hb == 8'hFF) begin
                              xacc_in = x_sat;
                           end else if (x_sat[SW]) begin
                              active_in = 1'b0;
                              rsp_wr    = 1'b1;
                              rsp_data  = blsp_pkg::make_rsp(32'd0, next_index_ff, 9'd1,
                                                             1'b1, blsp_pkg::ERR_RANGE);
                           end else begin
                              size_in  = x_sat[SW-1:0];
                              xacc_in  = '0;
                              state_in = ST_FRAME;
                           end
                        end else begin
                           if (e_bad) begin
                              active_in = 1'b0;
                              rsp_wr    = 1'b1;
                              rsp_data  = blsp_pkg::make_rsp(32'd0, next_index_ff, 9'd1,
                                                             1'b1, blsp_pkg::ERR_INT);
                           end else begin
                              if (e_first) ilen_in = e_len;
                              ibl_in  = e_bl_next;
                              eacc_in = e_acc_next;
                              if (e_bl_next == '0) state_in = ST_EB_SUB;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_DIV: begin
            if (div_stat.done && !rsp_full) begin
               rsp_wr = 1'b1;
               if (div_stat.remainder != '0) begin
                  rsp_data = blsp_pkg::make_rsp(32'd0, 8'd0, 9'd1, 1'b1,
                                                blsp_pkg::ERR_FIXED);
               end else begin
                  rsp_data = blsp_pkg::make_rsp(32'(div_stat.quotient), 8'd0, count_ff,
                                                1'b1, blsp_pkg::ERR_OK);
               end
               state_in = ST_IDLE;
            end
         end

         ST_EB_SUB: begin
            delta_in = EB_W'(eacc_ff) - bias;
            eacc_in  = '0;
            state_in = ST_EB_ADD;
         end

         ST_EB_ADD: begin
            if (e_range) begin
               if (!rsp_full) begin
                  active_in = 1'b0;
                  rsp_wr    = 1'b1;
                  rsp_data  = blsp_pkg::make_rsp(32'd0, next_index_ff, 9'd1, 1'b1,
                                                 blsp_pkg::ERR_RANGE);
                  state_in  = ST_IDLE;
               end
            end else begin
               size_in  = SW'(e_sum);
               state_in = ST_FRAME;
            end
         end

         ST_FRAME: begin
            if (!rsp_full) begin
               rsp_wr        = 1'b1;
               rsp_data      = blsp_pkg::make_rsp(32'(size_ff), next_index_ff, 9'd1, 1'b0,
                                                  blsp_pkg::ERR_OK);
               total_in      = t_sat;
               prev_in       = size_ff;
               next_index_in = next_index_ff + 8'd1;
               sizes_left_in = sizes_left_ff - 8'd1;
               state_in      = (sizes_left_ff == 8'd1) ? ST_LAST_SUM : ST_IDLE;
            end
         end

         ST_LAST_SUM: begin
            used_in  = USED_W'(header_length_ff) + USED_W'(total_ff);
            state_in = ST_LAST_OUT;
         end

         ST_LAST_OUT: begin
            if (!rsp_full) begin
               rsp_wr    = 1'b1;
               active_in = 1'b0;
               if (used_ff > USED_W'(block_length_ff)) begin
                  rsp_data = blsp_pkg::make_rsp(32'd0, next_index_ff, 9'd1, 1'b1,
                                                blsp_pkg::ERR_RANGE);
               end else begin
                  rsp_data = blsp_pkg::make_rsp(32'(l_diff), next_index_ff, 9'd1, 1'b1,
                                                blsp_pkg::ERR_OK);
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         active_ff        <= 1'b0;
         mode_ff          <= blsp_pkg::LACE_NONE;
         sizes_left_ff    <= 8'd0;
         next_index_ff    <= 8'd0;
         block_length_ff  <= 32'd0;
         header_length_ff <= 32'd0;
         xacc_ff          <= '0;
         eacc_ff          <= '0;
         ibl_ff           <= '0;
         ilen_ff          <= '0;
         prev_ff          <= '0;
         total_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         active_ff        <= active_in;
         mode_ff          <= mode_in;
         sizes_left_ff    <= sizes_left_in;
         next_index_ff    <= next_index_in;
         block_length_ff  <= block_length_in;
         header_length_ff <= header_length_in;
         xacc_ff          <= xacc_in;
         eacc_ff          <= eacc_in;
         ibl_ff           <= ibl_in;
         ilen_ff          <= ilen_in;
         prev_ff          <= prev_in;
         total_ff         <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff  <= size_in;
      delta_ff <= delta_in;
      used_ff  <= used_in;
      count_ff <= count_in;
   end

   `BLSP_ASSERT_IMPL(a_wr_room, clock, reset, rsp_wr, !rsp_full, "result write into full queue")
   `BLSP_ASSERT_IMPL(a_div_live, clock, reset, state_ff == ST_DIV, div_stat.busy || div_stat.done, "waiting on idle divider")
   `BLSP_ASSERT_IMPL(a_active_mode, clock, reset, active_ff, mode_ff == blsp_pkg::LACE_XIPH || mode_ff == blsp_pkg::LACE_EBML, "active block in wrong mode")
   `BLSP_ASSERT_IMPL(a_sizes_left, clock, reset, active_ff && state_ff == ST_IDLE, sizes_left_ff != 8'd0, "active block with no sizes left")
   `BLSP_ASSERT_NEXT(a_last_ends, clock, reset, state_ff == ST_LAST_OUT && !rsp_full, !active_ff && state_ff == ST_IDLE, "block did not end after last frame")

endmodule

// File: hdl/block_lace_size_parser.sv
// Top level of the block lace size parser: input queue, sequencer, divider, result queue.
// Depends on blsp_pkg, blsp_front, blsp_back, blsp_divider and blsp_rsp_queue.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  request  | push / full          | req_start_req req_lacing req_data_size
//           |                      | req_header_byte
//  response | empty / pop          | rsp_frame_size rsp_frame_index rsp_repeat_count
//           |                      | rsp_last rsp_error
//
// The sequencer takes one queued item per cycle while no size completes and the result
// queue has room. A finished size goes via ST_FRAME (ebml: ST_EB_SUB, ST_EB_ADD first);
// a last frame adds ST_LAST_SUM, ST_LAST_OUT. A fixed start waits on the
// one-bit-per-cycle divider. Reset is synchronous, active high, and empties both queues.
// A full result queue stalls the sequencer only; up to four items still queue in.
module block_lace_size_parser (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        push,
   output logic        full,
   input  logic        req_start_req,
   input  logic [1:0]  req_lacing,
   input  logic [31:0] req_data_size,
   input  logic [7:0]  req_header_byte,
   // response side
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_frame_size,
   output logic [7:0]  rsp_frame_index,
   output logic [8:0]  rsp_repeat_count,
   output logic        rsp_last,
   output logic [1:0]  rsp_error
);

   blsp_pkg::req_item_type q_head;
   logic                   q_valid;
   logic                   q_pop;
   blsp_pkg::div_req_type  div_req;
   blsp_pkg::div_stat_type div_stat;
   logic                   rsp_wr;
   blsp_pkg::rsp_item_type rsp_data;
   logic                   rsp_full;
   blsp_pkg::rsp_item_type rsp_head;

   // front end: every item lands here, already tagged with its class
   blsp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_start_req   (req_start_req),
      .req_lacing      (req_lacing),
      .req_data_size   (req_data_size),
      .req_header_byte (req_header_byte),
      .head            (q_head),
      .head_valid      (q_valid),
      .pop             (q_pop)
   );

   // fixed lacing split: payload / count with remainder check
   blsp_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   // sequencer: per-block state, size arithmetic, one result per cycle at most
   blsp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .div_req  (div_req),
      .div_stat (div_stat),
      .rsp_wr   (rsp_wr),
      .rsp_data (rsp_data),
      .rsp_full (rsp_full)
   );

   // results wait here until popped
   blsp_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (rsp_wr),
      .wr_data (rsp_data),
      .wr_full (rsp_full),
      .empty   (empty),
      .pop     (pop),
      .head    (rsp_head)
   );

   assign rsp_frame_size   = rsp_head.frame_size;
   assign rsp_frame_index  = rsp_head.frame_index;
   assign rsp_repeat_count = rsp_head.repeat_count;
   assign rsp_last         = rsp_head.last;
   assign rsp_error        = rsp_head.error;

endmodule
